### sv/alip_pkg.sv
package alip_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } in_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MALFORM  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_FLOAT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } out_t;

  typedef enum logic [11:0] {
    PH_START   = 12'b0000_0000_0001,
    PH_SIGNED  = 12'b0000_0000_0010,
    PH_ZERO    = 12'b0000_0000_0100,
    PH_DEC     = 12'b0000_0000_1000,
    PH_HEXPRE  = 12'b0000_0001_0000,
    PH_HEX     = 12'b0000_0010_0000,
    PH_KWTRUE  = 12'b0000_0100_0000,
    PH_KWFALSE = 12'b0000_1000_0000,
    PH_BAD     = 12'b0001_0000_0000,
    PH_OVFDEC  = 12'b0010_0000_0000,
    PH_FLOAT   = 12'b0100_0000_0000,
    PH_OVFHEX  = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic advance;
    logic last;
    logic at_start;
  } core_stat_t;

  localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;
  localparam logic [2:0]  TRUE_LEN  = 3'd4;
  localparam logic [2:0]  FALSE_LEN = 3'd5;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;

  function automatic logic [7:0] kw_char(input logic is_false, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_false) begin
      unique case (pos)
        3'd0: ch = 8'h66;
        3'd1: ch = 8'h61;
        3'd2: ch = 8'h6c;
        3'd3: ch = 8'h73;
        3'd4: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (pos)
        3'd0: ch = 8'h74;
        3'd1: ch = 8'h72;
        3'd2: ch = 8'h75;
        3'd3: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
    end
    return r;
  endfunction

endpackage

### sv/ascii_integer_literal_parser.sv
// Flow: a request enters the input register, is parsed while it is held there, and
//   the result of a final character is registered in the output register.
// Throughput: one character per cycle unless output stalls; the sign/digit/keyword
//   step and the times-ten shift-add sit in one stage between the two registers.
// Reset (rst_n low, synchronous): both registers empty, parser at start of literal.
module ascii_integer_literal_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  alip_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output alip_pkg::out_t out_data
);

  logic                 take;
  logic                 held_valid;
  alip_pkg::in_t        held_data;
  logic                 out_free;
  logic                 res_valid;
  alip_pkg::out_t       res;
  alip_pkg::core_stat_t stat;

  alip_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  alip_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (held_valid),
    .item       (held_data),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .stat       (stat)
  );

  alip_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    stat.advance && stat.last |=> out_valid && stat.at_start)
    else $error("final character did not produce a result or clear parser state");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != alip_pkg::ST_OK) |-> out_data.value == 64'd0)
    else $error("non-ok result carries a nonzero value");

  a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> stat.advance || !in_ready)
    else $error("input register ready while holding an unparsed request");

endmodule

### sv/alip_in_stage.sv
module alip_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  alip_pkg::in_t  in_data,
  input  logic           take,
  output logic           held_valid,
  output alip_pkg::in_t  held_data
);

  logic          valid_r, valid_nxt;
  alip_pkg::in_t data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign held_valid = valid_r;
  assign held_data  = data_r;

endmodule

### sv/alip_core.sv
module alip_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  alip_pkg::in_t        item,
  input  logic                 out_free,
  output logic                 take,
  output logic                 res_valid,
  output alip_pkg::out_t       res,
  output alip_pkg::core_stat_t stat
);

  alip_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [63:0]      nacc_r, nacc_nxt;
  logic             neg_r, neg_nxt;
  logic [2:0]       kwpos_r, kwpos_nxt;

  logic [7:0]  c;
  logic        is_dec;
  logic [3:0]  dval;
  logic [4:0]  hd;
  logic [63:0] acc10, nacc10, acc16, nacc16;
  logic        dec_ovf, hex_ovf;
  logic        do_dec, do_hex;
  logic        kw_false;
  logic [2:0]  kw_len;
  logic        kw_ok;
  logic        advance;

  assign c       = item.character;
  assign is_dec  = (c >= alip_pkg::CH_ZERO) && (c <= alip_pkg::CH_NINE);
  assign dval    = c[3:0];
  assign hd      = alip_pkg::hex_digit(c);
  assign acc10   = (acc_r << 3) + (acc_r << 1) + {60'd0, dval};
  assign nacc10  = (nacc_r << 3) + (nacc_r << 1) - {60'd0, dval};
  assign acc16   = {acc_r[59:0], hd[3:0]};
  assign nacc16  = {nacc_r[59:0], 4'd0} - {60'd0, hd[3:0]};
  assign dec_ovf = (acc_r > alip_pkg::DEC_LIMIT) ||
                   ((acc_r == alip_pkg::DEC_LIMIT) && (dval > 4'd5));
  assign hex_ovf = |acc_r[63:60];

  assign kw_false = (phase_r == alip_pkg::PH_KWFALSE);
  assign kw_len   = kw_false ? alip_pkg::FALSE_LEN : alip_pkg::TRUE_LEN;
  assign kw_ok    = (kwpos_r < kw_len) && (alip_pkg::kw_char(kw_false, kwpos_r) == c);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    nacc_nxt  = nacc_r;
    neg_nxt   = neg_r;
    kwpos_nxt = kwpos_r;
    do_dec    = 1'b0;
    do_hex    = 1'b0;
    unique case (phase_r) inside
      alip_pkg::PH_START: begin
        if (c == alip_pkg::CH_PLUS || c == alip_pkg::CH_MINUS) begin
          neg_nxt   = (c == alip_pkg::CH_MINUS);
          phase_nxt = alip_pkg::PH_SIGNED;
        end else if (c == alip_pkg::CH_ZERO) begin
          phase_nxt = alip_pkg::PH_ZERO;
        end else if (is_dec) begin
          do_dec = 1'b1;
        end else if (c == alip_pkg::CH_T) begin
          phase_nxt = alip_pkg::PH_KWTRUE;
          kwpos_nxt = 3'd1;
        end else if (c == alip_pkg::CH_F) begin
          phase_nxt = alip_pkg::PH_KWFALSE;
          kwpos_nxt = 3'd1;
        end else begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_SIGNED: begin
        if (c == alip_pkg::CH_ZERO) begin
          phase_nxt = alip_pkg::PH_ZERO;
        end else if (is_dec) begin
          do_dec = 1'b1;
        end else begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_ZERO: begin
        if (c == alip_pkg::CH_LX || c == alip_pkg::CH_UX) begin
          phase_nxt = alip_pkg::PH_HEXPRE;
        end else if (c == alip_pkg::CH_DOT) begin
          phase_nxt = alip_pkg::PH_FLOAT;
        end else if (is_dec) begin
          do_dec = 1'b1;
        end else begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_DEC: begin
        if (c == alip_pkg::CH_DOT) begin
          phase_nxt = alip_pkg::PH_FLOAT;
        end else if (is_dec) begin
          do_dec = 1'b1;
        end else begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_HEXPRE, alip_pkg::PH_HEX: begin
        if (hd[4]) begin
          do_hex = 1'b1;
        end else begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_KWTRUE, alip_pkg::PH_KWFALSE: begin
        if (kw_ok) begin
          kwpos_nxt = kwpos_r + 3'd1;
        end else begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_OVFDEC: begin
        if (c == alip_pkg::CH_DOT) begin
          phase_nxt = alip_pkg::PH_FLOAT;
        end else if (!is_dec) begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_OVFHEX: begin
        if (!hd[4]) begin
          phase_nxt = alip_pkg::PH_BAD;
        end
      end
      alip_pkg::PH_FLOAT: begin
        phase_nxt = alip_pkg::PH_FLOAT;
      end
      default: begin
        phase_nxt = alip_pkg::PH_BAD;
      end
    endcase

    if (do_dec) begin
      if (dec_ovf) begin
        phase_nxt = alip_pkg::PH_OVFDEC;
      end else begin
        acc_nxt   = acc10;
        nacc_nxt  = nacc10;
        phase_nxt = alip_pkg::PH_DEC;
      end
    end
    if (do_hex) begin
      if (hex_ovf) begin
        phase_nxt = alip_pkg::PH_OVFHEX;
      end else begin
        acc_nxt   = acc16;
        nacc_nxt  = nacc16;
        phase_nxt = alip_pkg::PH_HEX;
      end
    end
  end

  always_comb begin
    res.value  = 64'd0;
    res.status = alip_pkg::ST_MALFORM;
    unique case (phase_nxt) inside
      alip_pkg::PH_ZERO, alip_pkg::PH_DEC, alip_pkg::PH_HEXPRE, alip_pkg::PH_HEX: begin
        res.value  = neg_nxt ? nacc_nxt : acc_nxt;
        res.status = alip_pkg::ST_OK;
      end
      alip_pkg::PH_KWTRUE: begin
        if (kwpos_nxt == alip_pkg::TRUE_LEN) begin
          res.value  = 64'd1;
          res.status = alip_pkg::ST_OK;
        end
      end
      alip_pkg::PH_KWFALSE: begin
        if (kwpos_nxt == alip_pkg::FALSE_LEN) begin
          res.status = alip_pkg::ST_OK;
        end
      end
      alip_pkg::PH_OVFDEC, alip_pkg::PH_OVFHEX: begin
        res.status = alip_pkg::ST_OVERFLOW;
      end
      alip_pkg::PH_FLOAT: begin
        res.status = alip_pkg::ST_FLOAT;
      end
      default: begin
        res.status = alip_pkg::ST_MALFORM;
      end
    endcase
  end

  assign advance   = item_valid && out_free;
  assign take      = advance;
  assign res_valid = advance && item.is_last;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && item.is_last)) begin
      phase_r <= alip_pkg::PH_START;
      acc_r   <= 64'd0;
      nacc_r  <= 64'd0;
      neg_r   <= 1'b0;
      kwpos_r <= 3'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      nacc_r  <= nacc_nxt;
      neg_r   <= neg_nxt;
      kwpos_r <= kwpos_nxt;
    end
  end

  assign stat.advance  = advance;
  assign stat.last     = item.is_last;
  assign stat.at_start = (phase_r == alip_pkg::PH_START) && (acc_r == 64'd0) &&
                         (nacc_r == 64'd0) && !neg_r && (kwpos_r == 3'd0);

endmodule

### sv/alip_out_stage.sv
module alip_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  alip_pkg::out_t res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_ready,
  output alip_pkg::out_t out_data
);

  logic           valid_r, valid_nxt;
  alip_pkg::out_t data_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = out_free ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
